// File: rtl/core/efrc_pkg.sv
// Shared types, constants and verdict codes for the Ethernet receive classifier.
`timescale 1ns / 1ps
package efrc_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;
  localparam int unsigned HDR_KEEP = 42;
  localparam logic [31:0] OWN_IP_RST = 32'h0A00_0002;
  localparam logic [31:0] GW_IP_RST  = 32'h0A14_0001;

  typedef enum logic [0:0] {
    REG_OWN_IP = 1'b0,
    REG_GW_IP  = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    V_SHORT        = 5'd0,
    V_ARP_REQ_OURS = 5'd1,
    V_ARP_REQ_OTH  = 5'd2,
    V_ARP_GW_REPLY = 5'd3,
    V_ARP_REP_OTH  = 5'd4,
    V_ARP_BAD      = 5'd5,
    V_ARP_OPCODE   = 5'd6,
    V_IP_BAD_HDR   = 5'd7,
    V_IP_FRAG      = 5'd8,
    V_IP_CSUM      = 5'd9,
    V_IP_NOT_OURS  = 5'd10,
    V_ECHO_REQ     = 5'd11,
    V_ICMP_OTHER   = 5'd12,
    V_ICMP_BAD     = 5'd13,
    V_TCP          = 5'd14,
    V_UDP          = 5'd15,
    V_IP_PROTO_UNK = 5'd16,
    V_IPV6         = 5'd17,
    V_OTHER        = 5'd18
  } verdict_t;

  // Snapshot of a finished frame handed from front to back.
  typedef struct packed {
    logic [41:0][7:0] hdr;
    logic [15:0]      len;
    logic [15:0]      ip_sum;
    logic [15:0]      icmp_sum;
  } frame_snap_t;

  // Verdict and fields of one result item.
  typedef struct packed {
    verdict_t    verdict;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [15:0] ip_payload_length;
    logic [15:0] ip_identification;
    logic        gw_mac_known;
    logic [47:0] gw_mac;
  } result_t;

  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

// File: rtl/core/efrc_front.sv
// Byte-stream front end: header capture, running checksums, frame snapshot.
`timescale 1ns / 1ps
module efrc_front import efrc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_vld,
  input  logic [7:0]  byte_dat,
  input  logic        byte_last,
  output logic        snap_vld,
  output frame_snap_t snap
);

  logic [CW-1:0]    cnt_r;
  logic [41:0][7:0] hdr_r;
  logic [15:0]      ip_sum_r, icmp_sum_r;
  logic [7:0]       hold_r;
  logic             snap_vld_r;
  frame_snap_t      snap_r;

  logic [41:0][7:0] hdr_nxt;
  logic [15:0]      ip_sum_nxt, icmp_sum_nxt;
  logic [7:0]       hold_nxt, v;
  logic [CW:0]      pos, end_pos;

  always_comb begin
    pos = {1'b0, cnt_r};
    hdr_nxt = hdr_r;
    if (pos < (CW+1)'(HDR_KEEP)) hdr_nxt[pos[5:0]] = byte_dat;
    ip_sum_nxt = ip_sum_r;
    icmp_sum_nxt = icmp_sum_r;
    hold_nxt = hold_r;
    end_pos = (CW+1)'({hdr_nxt[16], hdr_nxt[17]}) + (CW+1)'(14);
    if ({hdr_nxt[16], hdr_nxt[17]} > 16'(MAX_FRAME_BYTES)) end_pos = '1;
    v = byte_dat;
    if (pos >= 14 && pos <= 33) begin
      if (pos == 24 || pos == 25) v = '0;
      if (!pos[0]) hold_nxt = v;
      else ip_sum_nxt = oc_add(ip_sum_r, {hold_r, v});
    end else if (pos >= 34 && pos < end_pos) begin
      if (pos == 36 || pos == 37) v = '0;
      if (!pos[0]) begin
        if (pos + 1'b1 == end_pos) icmp_sum_nxt = oc_add(icmp_sum_r, {v, 8'd0});
        else hold_nxt = v;
      end else icmp_sum_nxt = oc_add(icmp_sum_r, {hold_r, v});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ip_sum_r <= '0;
      icmp_sum_r <= '0;
      hold_r <= '0;
      snap_vld_r <= 1'b0;
    end else begin
      snap_vld_r <= byte_vld && byte_last;
      if (byte_vld) begin
        if (byte_last) begin
          cnt_r <= '0;
          ip_sum_r <= '0;
          icmp_sum_r <= '0;
          hold_r <= '0;
        end else begin
          if (cnt_r != CW'(MAX_FRAME_BYTES - 1)) cnt_r <= cnt_r + 1'b1;
          ip_sum_r <= ip_sum_nxt;
          icmp_sum_r <= icmp_sum_nxt;
          hold_r <= hold_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld) hdr_r <= hdr_nxt;
    if (byte_vld && byte_last) begin
      snap_r.hdr <= hdr_nxt;
      snap_r.len <= 16'(pos) + 16'd1;
      snap_r.ip_sum <= ip_sum_nxt;
      snap_r.icmp_sum <= icmp_sum_nxt;
    end
  end

  assign snap_vld = snap_vld_r;
  assign snap = snap_r;

endmodule

// File: rtl/core/efrc_back.sv
// Back end: verdict decision on a frame snapshot and gateway MAC learning.
`timescale 1ns / 1ps
module efrc_back import efrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        snap_vld,
  input  frame_snap_t snap,
  input  logic [31:0] own_ip,
  input  logic [31:0] gw_ip,
  output logic        res_vld,
  output result_t     res
);

  logic [47:0] gw_mac_r;
  logic        gw_vld_r;
  logic        res_vld_r;
  result_t     res_r;

  logic [41:0][7:0] h;
  logic [15:0] et, total, flg;
  logic        learn;
  result_t     r;

  always_comb begin
    h = snap.hdr;
    et = {h[12], h[13]};
    total = {h[16], h[17]};
    flg = {h[20], h[21]};
    learn = 1'b0;
    r = '0;
    r.verdict = V_OTHER;
    if (snap.len < 16'd14) r.verdict = V_SHORT;
    else begin
      r.sender_mac = {h[6], h[7], h[8], h[9], h[10], h[11]};
      if (et == 16'h0806) begin
        if (snap.len < 16'd42) r.verdict = V_SHORT;
        else begin
          r.sender_ip = {h[28], h[29], h[30], h[31]};
          if ({h[14], h[15]} != 16'h0001 || {h[16], h[17]} != 16'h0800 ||
              h[18] != 8'd6 || h[19] != 8'd4) r.verdict = V_ARP_BAD;
          else if ({h[20], h[21]} == 16'd1)
            r.verdict = ({h[38], h[39], h[40], h[41]} == own_ip) ?
                        V_ARP_REQ_OURS : V_ARP_REQ_OTH;
          else if ({h[20], h[21]} == 16'd2) begin
            if (r.sender_ip == gw_ip) begin
              r.verdict = V_ARP_GW_REPLY;
              learn = 1'b1;
            end else r.verdict = V_ARP_REP_OTH;
          end else r.verdict = V_ARP_OPCODE;
        end
      end else if (et == 16'h0800) begin
        if (snap.len < 16'd34) r.verdict = V_SHORT;
        else begin
          r.sender_ip = {h[26], h[27], h[28], h[29]};
          r.ip_identification = {h[18], h[19]};
          if (total >= 16'd20) r.ip_payload_length = total - 16'd20;
          if (h[14] != 8'h45 || total < 16'd20 ||
              {1'b0, snap.len} < {1'b0, total} + 17'd18) r.verdict = V_IP_BAD_HDR;
          else if (flg[13] || flg[15]) r.verdict = V_IP_FRAG;
          else if (~snap.ip_sum != {h[24], h[25]}) r.verdict = V_IP_CSUM;
          else if ({h[30], h[31], h[32], h[33]} != own_ip) r.verdict = V_IP_NOT_OURS;
          else begin
            case (h[23])
              8'd1: begin
                if (total < 16'd24 || ~snap.icmp_sum != {h[36], h[37]})
                  r.verdict = V_ICMP_BAD;
                else r.verdict = (h[34] == 8'd8) ? V_ECHO_REQ : V_ICMP_OTHER;
              end
              8'd6:    r.verdict = V_TCP;
              8'd17:   r.verdict = V_UDP;
              default: r.verdict = V_IP_PROTO_UNK;
            endcase
          end
        end
      end else if (et == 16'h86DD) r.verdict = V_IPV6;
    end
    r.gw_mac_known = gw_vld_r || learn;
    r.gw_mac = learn ? {h[22], h[23], h[24], h[25], h[26], h[27]} : gw_mac_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_mac_r <= '0;
      gw_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= snap_vld;
      if (snap_vld && learn) begin
        gw_mac_r <= r.gw_mac;
        gw_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_vld) res_r <= r;
  end

  assign res_vld = res_vld_r;
  assign res = res_r;

  property p_learn_sets_valid;
    @(posedge clk) disable iff (!rst_n) (snap_vld && learn) |=> gw_vld_r;
  endproperty
  a_learn: assert property (p_learn_sets_valid) else $error("gateway learn lost");

  property p_valid_sticky;
    @(posedge clk) disable iff (!rst_n) gw_vld_r |=> gw_vld_r;
  endproperty
  a_sticky: assert property (p_valid_sticky) else $error("gateway valid dropped");

  property p_res_follows;
    @(posedge clk) disable iff (!rst_n) snap_vld |=> res_vld;
  endproperty
  a_res: assert property (p_res_follows) else $error("result lost");

endmodule

// File: rtl/core/efrc_resq.sv
// Small result queue between the verdict stage and the output port.
`timescale 1ns / 1ps
module efrc_resq import efrc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr,
  input  result_t wdat,
  input  logic    rd,
  output logic    empty,
  output logic    afull,
  output result_t rdat
);

  localparam int unsigned DEPTH = 4;
  result_t    mem_r [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       do_rd;

  assign empty = (cnt_r == 3'd0);
  assign do_rd = rd && !empty;
  // two results may still be in flight behind the push port
  assign afull = (cnt_r >= 3'd2);
  assign rdat = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {2'd0, wr} - {2'd0, do_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdat;
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) wr |-> (cnt_r < 3'd4 || do_rd);
  endproperty
  a_ovf: assert property (p_no_overflow) else $error("result queue overflow");

endmodule

// File: rtl/core/ethernet_frame_receive_classifier.sv
// Top level of the Ethernet receive classifier for ARP, IPv4 and ICMP.
`timescale 1ns / 1ps
// A frame's result passes the front snapshot and back result registers into the queue.
// One byte per cycle while full is low; front captures and sums, back decides per frame.
// full rises when the 4-entry result queue holds two or more results (room for
// those still in the front/back stages); while full is high no byte is accepted.
// Reset (rst_n low, synchronous): counters, sums, queue and learned gateway clear;
// own_ip returns to 10.0.0.2, gateway_ip to 10.20.0.1.
module ethernet_frame_receive_classifier import efrc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_verdict,
  output logic [47:0] out_sender_mac,
  output logic [31:0] out_sender_ip,
  output logic [15:0] out_ip_payload_length,
  output logic [15:0] out_ip_identification,
  output logic        out_gw_mac_known,
  output logic [47:0] out_gw_mac,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] own_ip_r, gw_ip_r;
  logic        acc, snap_vld, res_vld, afull;
  frame_snap_t snap;
  result_t     res, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= OWN_IP_RST;
      gw_ip_r <= GW_IP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_OWN_IP: own_ip_r <= cfg_wdata;
        REG_GW_IP:  gw_ip_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = afull;
  assign acc = in_push && !afull;

  efrc_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk, .rst_n, .byte_vld(acc), .byte_dat(in_frame_byte), .byte_last(in_last_byte),
    .snap_vld, .snap
  );

  efrc_back u_back (
    .clk, .rst_n, .snap_vld, .snap, .own_ip(own_ip_r), .gw_ip(gw_ip_r),
    .res_vld, .res
  );

  efrc_resq u_q (
    .clk, .rst_n, .wr(res_vld), .wdat(res), .rd(out_pop),
    .empty(out_empty), .afull, .rdat(q_out)
  );

  assign out_verdict = q_out.verdict;
  assign out_sender_mac = q_out.sender_mac;
  assign out_sender_ip = q_out.sender_ip;
  assign out_ip_payload_length = q_out.ip_payload_length;
  assign out_ip_identification = q_out.ip_identification;
  assign out_gw_mac_known = q_out.gw_mac_known;
  assign out_gw_mac = q_out.gw_mac;

endmodule

// File: test/tb.sv
// Self-checking testbench for the Ethernet receive classifier.
`timescale 1ns / 1ps
module tb;
  import efrc_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       l;
  } fbyte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_frame_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [4:0]  out_verdict;
  logic [47:0] out_sender_mac;
  logic [31:0] out_sender_ip;
  logic [15:0] out_ip_payload_length;
  logic [15:0] out_ip_identification;
  logic        out_gw_mac_known;
  logic [47:0] out_gw_mac;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_idx = REG_OWN_IP;
  logic [31:0] cfg_wdata = 32'd0;

  ethernet_frame_receive_classifier dut (.*);

  // Bytes waiting to be pushed; verdicts waiting to be popped.
  fbyte_t  byte_q[$];
  result_t verdict_q[$];
  int      fail_cnt = 0;
  bit      no_idle = 1'b0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;

  // Shadow of the classifier state.
  logic [31:0] m_own = OWN_IP_RST;
  logic [31:0] m_gw = GW_IP_RST;
  int unsigned m_pos = 0;
  logic [7:0]  m_hdr[42];
  logic [15:0] m_ipsum = 0, m_icsum = 0;
  logic [7:0]  m_hold = 0;
  logic [47:0] m_gwmac = 0;
  logic        m_gwok = 1'b0;

  initial forever #2 clk = ~clk;

  // --- shadow model -------------------------------------------------------
  function automatic logic [15:0] fold_add(logic [15:0] s, logic [15:0] w);
    logic [16:0] t;
    t = s + w;
    return t[15:0] + t[16];
  endfunction

  function automatic logic [15:0] hw16(int unsigned i);
    return {m_hdr[i % 42], m_hdr[(i + 1) % 42]};
  endfunction

  function automatic logic [31:0] hw32(int unsigned i);
    return {hw16(i), hw16(i + 2)};
  endfunction

  function automatic verdict_t arp_verdict(int unsigned len, ref result_t r);
    logic [15:0] op;
    if (len < 42) return V_SHORT;
    r.sender_ip = hw32(28);
    if (hw16(14) != 16'h0001 || hw16(16) != 16'h0800 || m_hdr[18] != 8'd6 || m_hdr[19] != 8'd4)
      return V_ARP_BAD;
    op = hw16(20);
    if (op == 16'd1) return (hw32(38) == m_own) ? V_ARP_REQ_OURS : V_ARP_REQ_OTH;
    if (op == 16'd2) begin
      if (r.sender_ip != m_gw) return V_ARP_REP_OTH;
      m_gwmac = {hw16(22), hw32(24)};
      m_gwok = 1'b1;
      return V_ARP_GW_REPLY;
    end
    return V_ARP_OPCODE;
  endfunction

  function automatic verdict_t ip_verdict(int unsigned len, ref result_t r);
    int unsigned total;
    logic [2:0]  flg;
    if (len < 34) return V_SHORT;
    r.sender_ip = hw32(26);
    r.ip_identification = hw16(18);
    total = hw16(16);
    if (total >= 20) r.ip_payload_length = total - 20;
    if (m_hdr[14] != 8'h45 || total < 20 || len < total + 18) return V_IP_BAD_HDR;
    flg = m_hdr[20][7:5];
    if (flg[0] || flg[2]) return V_IP_FRAG;
    if (~m_ipsum != hw16(24)) return V_IP_CSUM;
    if (hw32(30) != m_own) return V_IP_NOT_OURS;
    case (m_hdr[23])
      8'd1: begin
        if (total - 20 < 4 || ~m_icsum != hw16(36)) return V_ICMP_BAD;
        return (m_hdr[34] == 8'd8) ? V_ECHO_REQ : V_ICMP_OTHER;
      end
      8'd6: return V_TCP;
      8'd17: return V_UDP;
      default: return V_IP_PROTO_UNK;
    endcase
  endfunction

  // Advance the shadow by one accepted byte; a last byte queues a verdict.
  function automatic void track_byte(logic [7:0] b, logic last);
    int unsigned p, stop, len;
    logic [7:0]  v;
    logic [15:0] et;
    result_t     r;
    p = m_pos;
    if (p < 42) m_hdr[p] = b;
    if (p >= 14 && p <= 33) begin
      v = (p == 24 || p == 25) ? 8'd0 : b;
      if (p % 2 == 0) m_hold = v;
      else m_ipsum = fold_add(m_ipsum, {m_hold, v});
    end else if (p >= 34) begin
      stop = 14 + hw16(16);
      if (p < stop) begin
        v = (p == 36 || p == 37) ? 8'd0 : b;
        if (p % 2 == 1) m_icsum = fold_add(m_icsum, {m_hold, v});
        else if (p + 1 == stop) m_icsum = fold_add(m_icsum, {v, 8'd0});
        else m_hold = v;
      end
    end
    if (m_pos < 2047) m_pos++;
    if (!last) return;
    r = '0;
    len = p + 1;
    if (len < 14) r.verdict = V_SHORT;
    else begin
      r.sender_mac = {hw16(6), hw32(8)};
      et = hw16(12);
      if (et == 16'h0806) r.verdict = arp_verdict(len, r);
      else if (et == 16'h0800) r.verdict = ip_verdict(len, r);
      else if (et == 16'h86DD) r.verdict = V_IPV6;
      else r.verdict = V_OTHER;
    end
    r.gw_mac_known = m_gwok;
    r.gw_mac = m_gwmac;
    verdict_q.push_back(r);
    m_pos = 0;
    m_ipsum = 0;
    m_icsum = 0;
    m_hold = 0;
  endfunction

  // --- sender ---------------------------------------------------------------
  always @(negedge clk) begin
    if (byte_q.size() > 0 && (no_idle || $urandom_range(99) >= 13)) begin
      in_push <= 1'b1;
      in_frame_byte <= byte_q[0].b;
      in_last_byte <= byte_q[0].l;
    end else begin
      in_push <= 1'b0;
      in_frame_byte <= $urandom;
      in_last_byte <= $urandom;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      track_byte(in_frame_byte, in_last_byte);
      void'(byte_q.pop_front());
    end
  end

  // --- receiver: random pops, plus one long hold-off to back up the queue -----
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 400;
      out_pop <= 1'b0;
    end else begin
      out_pop <= no_idle || $urandom_range(99) >= 13;
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict exp none got %0d", $time, out_verdict);
        fail_cnt++;
      end else begin
        e = verdict_q.pop_front();
        if (out_verdict != e.verdict) begin
          $display("%0t: verdict exp %0d got %0d", $time, e.verdict, out_verdict);
          fail_cnt++;
        end
        if (out_sender_mac != e.sender_mac) begin
          $display("%0t: sender_mac exp %h got %h", $time, e.sender_mac, out_sender_mac);
          fail_cnt++;
        end
        if (out_sender_ip != e.sender_ip) begin
          $display("%0t: sender_ip exp %h got %h", $time, e.sender_ip, out_sender_ip);
          fail_cnt++;
        end
        if (out_ip_payload_length != e.ip_payload_length) begin
          $display("%0t: payload_len exp %0d got %0d", $time, e.ip_payload_length,
                   out_ip_payload_length);
          fail_cnt++;
        end
        if (out_ip_identification != e.ip_identification) begin
          $display("%0t: ident exp %h got %h", $time, e.ip_identification,
                   out_ip_identification);
          fail_cnt++;
        end
        if (out_gw_mac_known != e.gw_mac_known) begin
          $display("%0t: gw_known exp %b got %b", $time, e.gw_mac_known,
                   out_gw_mac_known);
          fail_cnt++;
        end
        if (out_gw_mac != e.gw_mac) begin
          $display("%0t: gw_mac exp %h got %h", $time, e.gw_mac, out_gw_mac);
          fail_cnt++;
        end
      end
    end
  end

  // --- frame builders ---------------------------------------------------------
  logic [7:0] fr[$];
  int         sent_bytes = 0;

  function automatic void put16(logic [15:0] v);
    fr.push_back(v[15:8]);
    fr.push_back(v[7:0]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  function automatic void put_rand(int n);
    repeat (n) fr.push_back($urandom);
  endfunction

  function automatic void eth_head(logic [15:0] etype);
    fr.delete();
    put_rand(12);
    put16(etype);
  endfunction

  // Ones' complement checksum over n bytes at start (checksum field pre-zeroed).
  function automatic logic [15:0] ones_sum(int start, int n);
    logic [15:0] s;
    s = 0;
    for (int i = 0; i < n; i += 2)
      s = fold_add(s, {fr[start + i], (i + 1 < n) ? fr[start + i + 1] : 8'd0});
    return ~s;
  endfunction

  // Queue the frame, cut to keep bytes when keep > 0.
  task automatic send(int keep);
    int n;
    n = (keep > 0 && keep < fr.size()) ? keep : fr.size();
    for (int i = 0; i < n; i++) byte_q.push_back('{fr[i], i == n - 1});
    sent_bytes += n;
  endtask

  task automatic gen_arp(logic [15:0] htype, logic [15:0] op, bit from_gw, bit to_us, int keep);
    eth_head(16'h0806);
    put16(htype);
    put16(16'h0800);
    fr.push_back(8'd6);
    fr.push_back(8'd4);
    put16(op);
    put_rand(6);
    put32(from_gw ? m_gw : $urandom);
    put_rand(6);
    put32(to_us ? m_own : $urandom);
    put_rand($urandom_range(0, 18) + 4);
    send(keep);
  endtask

  task automatic gen_ip(logic [7:0] vihl, int dlen, logic [2:0] flg, logic [7:0] proto,
                        logic [7:0] icmp_type, bit bad_ipcs, bit bad_iccs, bit to_us,
                        int pad, int keep);
    logic [15:0] c;
    eth_head(16'h0800);
    fr.push_back(vihl);
    fr.push_back($urandom);
    put16(20 + dlen);
    put16($urandom);
    fr.push_back({flg, 5'($urandom)});
    fr.push_back($urandom);
    fr.push_back($urandom);
    fr.push_back(proto);
    put16(16'd0);
    put32($urandom);
    put32(to_us ? m_own : $urandom);
    c = ones_sum(14, 20) ^ (bad_ipcs ? 16'($urandom_range(1, 65535)) : 16'd0);
    fr[24] = c[15:8];
    fr[25] = c[7:0];
    put_rand(dlen);
    if (dlen >= 1) fr[34] = icmp_type;
    if (dlen >= 4) begin
      fr[36] = 0;
      fr[37] = 0;
      c = ones_sum(34, dlen) ^ (bad_iccs ? 16'($urandom_range(1, 65535)) : 16'd0);
      fr[36] = c[15:8];
      fr[37] = c[7:0];
    end
    put_rand(pad + 4);
    send(keep);
  endtask

  task automatic gen_raw(logic [15:0] etype, int n);
    eth_head(etype);
    put_rand(n);
    send(0);
  endtask

  task automatic gen_random();
    int k;
    logic [7:0] pr;
    k = $urandom_range(99);
    pr = ($urandom_range(3) == 0) ? 8'($urandom) : (($urandom_range(2) == 0) ? 8'd1 :
         (($urandom_range(1) == 0) ? 8'd6 : 8'd17));
    if (k < 45) begin
      gen_ip(($urandom_range(9) == 0) ? 8'($urandom) : 8'h45, $urandom_range(0, 40),
             ($urandom_range(3) == 0) ? 3'($urandom) : 3'b010, pr,
             ($urandom_range(1) == 0) ? 8'd8 : 8'($urandom),
             $urandom_range(9) == 0, $urandom_range(7) == 0, $urandom_range(4) != 0,
             $urandom_range(0, 6), ($urandom_range(9) == 0) ? $urandom_range(1, 60) : 0);
    end else if (k < 80) begin
      gen_arp(($urandom_range(9) == 0) ? 16'($urandom) : 16'd1,
              ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2)),
              $urandom_range(1) == 0, $urandom_range(1) == 0,
              ($urandom_range(9) == 0) ? $urandom_range(1, 46) : 0);
    end else if (k < 88) begin
      gen_raw(($urandom_range(1) == 0) ? 16'h86DD : 16'($urandom), $urandom_range(0, 40));
    end else begin
      fr.delete();
      put_rand($urandom_range(1, 20));
      send(0);
    end
  endtask

  // Wait for the block to drain, then allow its pipeline to settle.
  task automatic drain();
    while (byte_q.size() > 0 || verdict_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OWN_IP) m_own = v;
    else m_gw = v;
  endtask

  // --- main sequence ----------------------------------------------------------
  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: one frame per verdict class except TCP, edges of length and header fields.
    fr.delete();
    put_rand(5);
    send(0);                                       // too short for Ethernet
    gen_raw(16'h0800, 0);                          // 14 bytes IPv4, too short
    gen_arp(16'd1, 16'd1, 0, 1, 0);                // request for us
    gen_arp(16'd1, 16'd1, 0, 0, 0);                // request for someone else
    gen_arp(16'd1, 16'd2, 0, 0, 0);                // reply, not gateway
    gen_arp(16'd1, 16'd2, 1, 0, 0);                // gateway reply, learned
    gen_arp(16'd2, 16'd1, 0, 1, 0);                // bad hardware type
    gen_arp(16'd1, 16'hFFFF, 0, 0, 0);             // unknown opcode
    gen_arp(16'd1, 16'd1, 0, 1, 41);               // ARP one byte short
    gen_ip(8'h46, 8, 3'b000, 8'd6, 0, 0, 0, 1, 0, 0);   // IHL not 5
    gen_ip(8'h45, 8, 3'b001, 8'd6, 0, 0, 0, 1, 0, 0);   // MF style flag
    gen_ip(8'h45, 8, 3'b100, 8'd6, 0, 0, 0, 1, 0, 0);   // reserved flag
    gen_ip(8'h45, 8, 3'b010, 8'd6, 0, 1, 0, 1, 0, 0);   // header checksum wrong
    gen_ip(8'h45, 8, 3'b010, 8'd6, 0, 0, 0, 0, 0, 0);   // not addressed to us
    gen_ip(8'h45, 9, 3'b000, 8'd1, 8, 0, 0, 1, 3, 0);   // echo request, odd length
    gen_ip(8'h45, 12, 3'b000, 8'd1, 0, 0, 0, 1, 0, 0);  // other ICMP
    gen_ip(8'h45, 2, 3'b000, 8'd1, 8, 0, 0, 1, 0, 0);   // ICMP too short
    gen_ip(8'h45, 16, 3'b000, 8'd1, 8, 0, 1, 1, 0, 0);  // ICMP checksum wrong
    gen_ip(8'h45, 0, 3'b000, 8'd17, 0, 0, 0, 1, 0, 0);  // UDP, empty payload
    gen_ip(8'h45, 20, 3'b000, 8'd255, 0, 0, 0, 1, 0, 0);// unknown protocol
    gen_ip(8'h45, 20, 3'b000, 8'd6, 0, 0, 0, 1, 0, 33); // cut below 34 bytes
    gen_ip(8'h45, 20, 3'b000, 8'd6, 0, 0, 0, 1, 0, 40); // total length exceeds frame
    gen_raw(16'h86DD, 30);
    gen_raw(16'hFFFF, 30);
    drain();

    // Register extremes, then random traffic in several phases.
    write_reg(REG_OWN_IP, 32'h0000_0000);
    write_reg(REG_GW_IP, 32'hFFFF_FFFF);
    while (sent_bytes < 1250) gen_random();
    drain();

    write_reg(REG_OWN_IP, 32'hFFFF_FFFF);
    write_reg(REG_GW_IP, 32'h0000_0000);
    no_idle = 1'b1;
    while (sent_bytes < 1500) gen_random();
    drain();
    no_idle = 1'b0;

    write_reg(REG_OWN_IP, $urandom);
    write_reg(REG_GW_IP, $urandom);
    @(posedge clk);
    hold_req = 1'b1;                               // receiver backs off, input stalls
    while (sent_bytes < 1950) gen_random();
    drain();

    if (fail_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
